[design/btmx_pkg.sv]
// ----------------------------------------------------------------------------
// btmx_pkg: shared types and constants of the binary trie max-XOR block
// Sizes of the node pool, key and tag fields, the item format passed from the
// front end to the walker, and the walker state encoding.
// ----------------------------------------------------------------------------
package btmx_pkg;

  localparam int KEY_BITS    = 32;
  localparam int TAG_BITS    = 10;
  localparam int NODE_COUNT  = 8192;
  localparam int NODE_BITS   = $clog2(NODE_COUNT);
  localparam int FREE_BITS   = NODE_BITS + 1;
  localparam int LEVEL_BITS  = $clog2(KEY_BITS);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  typedef struct packed {
    logic                is_query;
    logic [KEY_BITS-1:0] key;
    logic [TAG_BITS-1:0] tag;
  } item_t;

  typedef struct packed {
    logic                 busy;
    logic [FREE_BITS-1:0] nodes_used;
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_WALK,
    ST_ALLOC,
    ST_TAG,
    ST_FINISH
  } state_t;

endpackage

[design/btmx_front.sv]
// ----------------------------------------------------------------------------
// btmx_front: request intake and queue
// Accepts request items, decodes the operation and holds them in a short
// queue until the walker takes them.
// ----------------------------------------------------------------------------
module btmx_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_ready,
  input  logic                            operation,
  input  logic [btmx_pkg::KEY_BITS-1:0]   key,
  input  logic [btmx_pkg::TAG_BITS-1:0]   tag,
  output logic                            q_valid,
  output btmx_pkg::item_t                 q_item,
  input  logic                            q_pop
);

  btmx_pkg::item_t                    entries [btmx_pkg::QUEUE_DEPTH];
  logic [btmx_pkg::QPTR_BITS-1:0]     wr_ptr;
  logic [btmx_pkg::QPTR_BITS-1:0]     rd_ptr;
  logic [btmx_pkg::QCNT_BITS-1:0]     count;
  logic                               push;
  logic                               pop;
  btmx_pkg::item_t                    in_item;

  assign req_ready = (count != btmx_pkg::QCNT_BITS'(btmx_pkg::QUEUE_DEPTH));
  assign push      = req_valid && req_ready;
  assign pop       = q_pop && q_valid;
  assign q_valid   = (count != '0);
  assign q_item    = entries[rd_ptr];

  always_comb begin
    in_item.is_query = (operation == btmx_pkg::OP_QUERY);
    in_item.key      = key;
    in_item.tag      = tag;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + btmx_pkg::QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + btmx_pkg::QPTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + btmx_pkg::QCNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - btmx_pkg::QCNT_BITS'(1);
      end
    end
  end

endmodule

[design/btmx_back.sv]
// ----------------------------------------------------------------------------
// btmx_back: trie walker
// Owns the node pool memories and walks one trie level per cycle to insert
// a key or to find the best XOR partner, then holds the result item.
// ----------------------------------------------------------------------------
module btmx_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_valid,
  input  btmx_pkg::item_t                 q_item,
  output logic                            q_pop,
  output logic                            rsp_valid,
  input  logic                            rsp_ready,
  output logic [btmx_pkg::TAG_BITS-1:0]   match_tag,
  output logic                            match_found,
  output logic                            pool_full,
  output btmx_pkg::status_t               status
);

  localparam int NB = btmx_pkg::NODE_BITS;
  localparam int FB = btmx_pkg::FREE_BITS;
  localparam int LB = btmx_pkg::LEVEL_BITS;
  localparam int TB = btmx_pkg::TAG_BITS;

  // Node pool. Entry 0 of the link memories is unused: the root links live
  // in registers so that reset can clear them.
  logic [NB-1:0] mem_zero [btmx_pkg::NODE_COUNT];
  logic [NB-1:0] mem_one  [btmx_pkg::NODE_COUNT];
  logic [TB-1:0] mem_tag  [btmx_pkg::NODE_COUNT];

  btmx_pkg::state_t state;
  btmx_pkg::state_t state_next;

  btmx_pkg::item_t  item;
  logic [NB-1:0]    node;
  logic [LB-1:0]    level;
  logic [FB-1:0]    next_free;
  logic [NB-1:0]    root_zero;
  logic [NB-1:0]    root_one;
  logic [NB-1:0]    rd_zero;
  logic [NB-1:0]    rd_one;
  logic [TB-1:0]    rd_tag;
  logic [TB-1:0]    res_tag;
  logic             res_found;
  logic             res_full;

  logic             key_bit;
  logic             last;
  logic [NB-1:0]    cur_zero;
  logic [NB-1:0]    cur_one;
  logic [NB-1:0]    opp_child;
  logic [NB-1:0]    same_child;
  logic [NB-1:0]    walk_next;
  logic             missing;
  logic [FB-1:0]    free_left;
  logic [FB-1:0]    needed;
  logic             no_room;
  logic             root_empty;
  logic             out_free;
  logic [NB-1:0]    new_node;

  logic [NB-1:0]    rd_addr;
  logic             zero_we;
  logic             one_we;
  logic             tag_we;
  logic [NB-1:0]    wr_addr;
  logic [NB-1:0]    zero_wdata;
  logic [NB-1:0]    one_wdata;
  logic             root_zero_we;
  logic             root_one_we;

  assign key_bit    = item.key[level];
  assign last       = (level == '0);
  assign cur_zero   = (node == '0) ? root_zero : rd_zero;
  assign cur_one    = (node == '0) ? root_one  : rd_one;
  assign same_child = key_bit ? cur_one  : cur_zero;
  assign opp_child  = key_bit ? cur_zero : cur_one;
  assign new_node   = next_free[NB-1:0];
  assign root_empty = (root_zero == '0) && (root_one == '0);
  assign out_free   = !rsp_valid || rsp_ready;

  // A query prefers the child on the opposite bit; an insert follows the key.
  always_comb begin
    if (item.is_query && (opp_child != '0)) begin
      walk_next = opp_child;
    end else begin
      walk_next = same_child;
    end
  end

  assign missing   = (walk_next == '0);
  assign free_left = FB'(btmx_pkg::NODE_COUNT) - next_free;
  assign needed    = FB'(level) + FB'(1);
  assign no_room   = (needed > free_left);

  assign status.busy       = (state != btmx_pkg::ST_IDLE);
  assign status.nodes_used = next_free;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      btmx_pkg::ST_IDLE: begin
        if (q_valid) begin
          state_next = btmx_pkg::ST_SETUP;
        end
      end
      btmx_pkg::ST_SETUP: begin
        if (item.is_query && root_empty) begin
          state_next = btmx_pkg::ST_FINISH;
        end else begin
          state_next = btmx_pkg::ST_WALK;
        end
      end
      btmx_pkg::ST_WALK: begin
        if (item.is_query) begin
          if (missing || last) begin
            state_next = btmx_pkg::ST_TAG;
          end
        end else if (missing) begin
          state_next = no_room ? btmx_pkg::ST_FINISH : btmx_pkg::ST_ALLOC;
        end else if (last) begin
          state_next = btmx_pkg::ST_FINISH;
        end
      end
      btmx_pkg::ST_ALLOC: begin
        if (last) begin
          state_next = btmx_pkg::ST_FINISH;
        end
      end
      btmx_pkg::ST_TAG: begin
        state_next = btmx_pkg::ST_FINISH;
      end
      btmx_pkg::ST_FINISH: begin
        if (out_free) begin
          state_next = btmx_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = btmx_pkg::ST_IDLE;
      end
    endcase
  end

  // Memory and root-link controls.
  always_comb begin
    q_pop        = 1'b0;
    rd_addr      = node;
    zero_we      = 1'b0;
    one_we       = 1'b0;
    tag_we       = 1'b0;
    wr_addr      = node;
    zero_wdata   = '0;
    one_wdata    = '0;
    root_zero_we = 1'b0;
    root_one_we  = 1'b0;
    case (state)
      btmx_pkg::ST_IDLE: begin
        q_pop = q_valid;
      end
      btmx_pkg::ST_WALK: begin
        rd_addr = missing ? node : walk_next;
        if (!item.is_query) begin
          if (missing && !no_room) begin
            // Hook the first new node onto the existing parent.
            zero_wdata = new_node;
            one_wdata  = new_node;
            if (node == '0) begin
              root_zero_we = !key_bit;
              root_one_we  = key_bit;
            end else begin
              zero_we = !key_bit;
              one_we  = key_bit;
            end
          end else if (!missing && last) begin
            tag_we  = 1'b1;
            wr_addr = walk_next;
          end
        end
      end
      btmx_pkg::ST_ALLOC: begin
        // Each new node gets both links; only the path link is non-null (none at a leaf).
        zero_we = 1'b1;
        one_we  = 1'b1;
        if (last) begin
          tag_we = 1'b1;
        end else if (item.key[level - LB'(1)]) begin
          one_wdata = new_node;
        end else begin
          zero_wdata = new_node;
        end
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (zero_we) begin
      mem_zero[wr_addr] <= zero_wdata;
    end
    if (one_we) begin
      mem_one[wr_addr] <= one_wdata;
    end
    if (tag_we) begin
      mem_tag[wr_addr] <= item.tag;
    end
    rd_zero <= mem_zero[rd_addr];
    rd_one  <= mem_one[rd_addr];
    rd_tag  <= mem_tag[rd_addr];
  end

  // Item and walk registers.
  always_ff @(posedge clk) begin
    case (state)
      btmx_pkg::ST_IDLE: begin
        if (q_valid) begin
          item <= q_item;
        end
      end
      btmx_pkg::ST_SETUP: begin
        node      <= '0;
        level     <= LB'(btmx_pkg::KEY_BITS - 1);
        res_tag   <= '0;
        res_found <= item.is_query && !root_empty;
        res_full  <= 1'b0;
      end
      btmx_pkg::ST_WALK: begin
        if (missing) begin
          if (!item.is_query) begin
            if (no_room) begin
              res_full <= 1'b1;
            end else begin
              node <= new_node;
            end
          end
        end else begin
          node <= walk_next;
          if (!last) begin
            level <= level - LB'(1);
          end
        end
      end
      btmx_pkg::ST_ALLOC: begin
        if (!last) begin
          node  <= new_node;
          level <= level - LB'(1);
        end
      end
      btmx_pkg::ST_TAG: begin
        res_tag <= rd_tag;
      end
      default: begin
        res_tag <= res_tag;
      end
    endcase
    if (state == btmx_pkg::ST_FINISH && out_free) begin
      match_tag   <= res_tag;
      match_found <= res_found;
      pool_full   <= res_full;
    end
  end

  // Control state: state, pool allocation pointer, root links, result valid.
  // The leaf is allocated in the ALLOC or WALK cycle before it, so the ALLOC
  // cycle at level zero only writes the leaf and takes no node.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= btmx_pkg::ST_IDLE;
      next_free <= FB'(1);
      root_zero <= '0;
      root_one  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if ((state == btmx_pkg::ST_ALLOC && !last) ||
          (state == btmx_pkg::ST_WALK && !item.is_query && missing && !no_room)) begin
        next_free <= next_free + FB'(1);
      end
      if (root_zero_we) begin
        root_zero <= zero_wdata;
      end
      if (root_one_we) begin
        root_one <= one_wdata;
      end
      if (state == btmx_pkg::ST_FINISH && out_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

[design/binary_trie_max_xor.sv]
// ----------------------------------------------------------------------------
// binary_trie_max_xor: binary trie with insert and maximum-XOR query
// Stores 32-bit keys with 10-bit tags in a pool of 8192 nodes and answers
// which stored key gives the largest XOR with a query key.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------------
//   req     | in        | req_valid / req_ready | operation, key, tag
//   rsp     | out       | rsp_valid / rsp_ready | match_tag, match_found,
//           |           |                       | pool_full
//
// A query or an insert of a new key is taken from the queue, set up, walked one
// level at a time (with a tag read, or the first missing level seen twice) and
// its result loaded. A stored key's insert needs neither; an empty-trie query
// skips the walk. One level needs one registered link read. Reset clears the
// root links, allocation pointer, state, rsp_valid and queue only. Items wait
// in a two-entry queue while the walker is busy or the result waits on rsp_ready.
// ----------------------------------------------------------------------------
module binary_trie_max_xor (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_ready,
  input  logic                            operation,
  input  logic [btmx_pkg::KEY_BITS-1:0]   key,
  input  logic [btmx_pkg::TAG_BITS-1:0]   tag,
  output logic                            rsp_valid,
  input  logic                            rsp_ready,
  output logic [btmx_pkg::TAG_BITS-1:0]   match_tag,
  output logic                            match_found,
  output logic                            pool_full
);

  logic              q_valid;
  logic              q_pop;
  btmx_pkg::item_t   q_item;
  btmx_pkg::status_t status;

  btmx_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .operation (operation),
    .key       (key),
    .tag       (tag),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  btmx_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .match_tag   (match_tag),
    .match_found (match_found),
    .pool_full   (pool_full),
    .status      (status)
  );

  // The walker only takes an item from the queue when it is idle and one waits.
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (q_valid && !status.busy))
    else $error("queue popped while walker busy or queue empty");

  // A dropped insert never reports a match.
  a_full_no_match: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && pool_full) |-> (!match_found && (match_tag == '0)))
    else $error("dropped insert reports a match");

  // The allocation pointer stays within the pool and never moves back.
  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
    (status.nodes_used != '0) &&
    (status.nodes_used <= btmx_pkg::FREE_BITS'(btmx_pkg::NODE_COUNT)))
    else $error("allocation pointer out of range");

  a_pool_grows: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (status.nodes_used >= $past(status.nodes_used)))
    else $error("allocation pointer moved back");

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb: self-checking bench for binary_trie_max_xor
// Drives insert and lookup items through the valid/ready request channel,
// keeps its own copy of the trie to work out each expected result, and
// compares every response field by field. The run covers empty-trie lookups,
// tag overwrite, extreme keys, and filling the node pool until inserts are
// refused. Both sides idle at random, and the response side holds off once
// long enough to back the block up.
// ----------------------------------------------------------------------------
module tb;

  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 80;

  localparam int KEY_FRESH  = 0;
  localparam int KEY_NEAR   = 1;
  localparam int KEY_REPEAT = 2;

  typedef struct packed {
    logic [btmx_pkg::TAG_BITS-1:0] tag;
    logic                          found;
    logic                          full;
  } answer_t;

  // Mirror of the node pool; every accepted item updates it in order.
  class trie_mirror;
    logic [btmx_pkg::NODE_BITS-1:0] zero_link [btmx_pkg::NODE_COUNT];
    logic [btmx_pkg::NODE_BITS-1:0] one_link  [btmx_pkg::NODE_COUNT];
    logic [btmx_pkg::TAG_BITS-1:0]  leaf_tags [btmx_pkg::NODE_COUNT];
    int                             free_ptr;
    answer_t                        pending_answers [$];
    int                             mismatches;
    int                             answers_seen;
    int                             refusals;
    int                             empty_lookups;

    function new();
      int n;
      for (n = 0; n < btmx_pkg::NODE_COUNT; n++) begin
        zero_link[n] = '0;
        one_link[n]  = '0;
        leaf_tags[n] = '0;
      end
      free_ptr      = 1;
      mismatches    = 0;
      answers_seen  = 0;
      refusals      = 0;
      empty_lookups = 0;
    endfunction

    function int nodes_left();
      return btmx_pkg::NODE_COUNT - free_ptr;
    endfunction

    function answer_t insert_key(logic [btmx_pkg::KEY_BITS-1:0] k,
                                 logic [btmx_pkg::TAG_BITS-1:0] t);
      int node, nxt, lvl, needed;
      bit walking;
      answer_t a;
      a = '0;
      node = 0;
      needed = 0;
      walking = 1'b1;
      // The whole insert is dropped if the missing part of the path does not fit.
      for (lvl = btmx_pkg::KEY_BITS - 1; lvl >= 0 && walking; lvl--) begin
        nxt = int'(k[lvl] ? one_link[node] : zero_link[node]);
        if (nxt == 0) begin
          needed = lvl + 1;
          walking = 1'b0;
        end else begin
          node = nxt;
        end
      end
      if (needed > btmx_pkg::NODE_COUNT - free_ptr) begin
        refusals++;
        a.full = 1'b1;
        return a;
      end
      node = 0;
      for (lvl = btmx_pkg::KEY_BITS - 1; lvl >= 0; lvl--) begin
        nxt = int'(k[lvl] ? one_link[node] : zero_link[node]);
        if (nxt == 0) begin
          nxt = free_ptr;
          free_ptr++;
          zero_link[nxt] = '0;
          one_link[nxt]  = '0;
          leaf_tags[nxt] = '0;
          if (k[lvl]) one_link[node] = btmx_pkg::NODE_BITS'(nxt);
          else zero_link[node] = btmx_pkg::NODE_BITS'(nxt);
        end
        node = nxt;
      end
      leaf_tags[node] = t;
      return a;
    endfunction

    function answer_t query_key(logic [btmx_pkg::KEY_BITS-1:0] k);
      int node, nxt, lvl;
      answer_t a;
      a = '0;
      if (zero_link[0] == '0 && one_link[0] == '0) begin
        empty_lookups++;
        return a;
      end
      // Every stored key has a full-depth path, so some child always exists.
      node = 0;
      for (lvl = btmx_pkg::KEY_BITS - 1; lvl >= 0; lvl--) begin
        nxt = int'(k[lvl] ? zero_link[node] : one_link[node]);
        if (nxt == 0) nxt = int'(k[lvl] ? one_link[node] : zero_link[node]);
        node = nxt;
      end
      a.found = 1'b1;
      a.tag   = leaf_tags[node];
      return a;
    endfunction

    function void note_request(logic op, logic [btmx_pkg::KEY_BITS-1:0] k,
                               logic [btmx_pkg::TAG_BITS-1:0] t);
      answer_t a;
      if (op == btmx_pkg::OP_QUERY) a = query_key(k);
      else a = insert_key(k, t);
      pending_answers = {pending_answers, a};
    endfunction

    function void check_response(logic [btmx_pkg::TAG_BITS-1:0] mt, logic mf, logic pf);
      answer_t want;
      answers_seen++;
      if (pending_answers.size() == 0) begin
        $error("result with no item outstanding: match_tag %0d match_found %0b pool_full %0b",
               mt, mf, pf);
        mismatches++;
        return;
      end
      want = pending_answers.pop_front();
      if (mt !== want.tag) begin
        $error("match_tag: expected %0d, got %0d", want.tag, mt);
        mismatches++;
      end
      if (mf !== want.found) begin
        $error("match_found: expected %0b, got %0b", want.found, mf);
        mismatches++;
      end
      if (pf !== want.full) begin
        $error("pool_full: expected %0b, got %0b", want.full, pf);
        mismatches++;
      end
    endfunction
  endclass

  logic                          clk;
  logic                          rst;
  logic                          req_valid;
  logic                          req_ready;
  logic                          operation;
  logic [btmx_pkg::KEY_BITS-1:0] key;
  logic [btmx_pkg::TAG_BITS-1:0] tag;
  logic                          rsp_valid;
  logic                          rsp_ready;
  logic [btmx_pkg::TAG_BITS-1:0] match_tag;
  logic                          match_found;
  logic                          pool_full;

  trie_mirror                    mirror;
  logic [btmx_pkg::KEY_BITS-1:0] known_keys [$];
  bit                            quiet;
  bit                            hold_rsp;
  int                            stall_count;
  int                            items_sent;
  int                            inserts_sent;
  int                            queries_sent;

  binary_trie_max_xor dut (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .operation   (operation),
    .key         (key),
    .tag         (tag),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .match_tag   (match_tag),
    .match_found (match_found),
    .pool_full   (pool_full)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) mirror.note_request(operation, key, tag);
      if (rsp_valid && rsp_ready) mirror.check_response(match_tag, match_found, pool_full);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
        stall_count = 0;
      end else begin
        stall_count++;
        if (stall_count >= STALL_LIMIT) begin
          $display("tb: no item moved for %0d cycles", STALL_LIMIT);
          $display("tb: done, errors");
          $finish;
        end
      end
    end
  end

  // Response side: random back-pressure, plus one long hold-off on request.
  initial begin : receiver
    int gap;
    rsp_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_rsp) begin
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rsp = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        rsp_ready <= 1'b0;
        gap = $urandom_range(1, 10);
        repeat (gap) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic offer(logic op, logic [btmx_pkg::KEY_BITS-1:0] k,
                       logic [btmx_pkg::TAG_BITS-1:0] t);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      gap = $urandom_range(1, 10);
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    operation <= op;
    key       <= k;
    tag       <= t;
    do @(posedge clk); while (!req_ready);
    items_sent++;
    if (op == btmx_pkg::OP_QUERY) begin
      queries_sent++;
    end else begin
      inserts_sent++;
      known_keys = {known_keys, k};
    end
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (mirror.pending_answers.size() != 0) @(posedge clk);
  endtask

  function automatic logic [btmx_pkg::KEY_BITS-1:0] pick_key(int src);
    logic [btmx_pkg::KEY_BITS-1:0] base;
    if (src == KEY_FRESH || known_keys.size() == 0) return $urandom;
    base = known_keys[$urandom_range(0, known_keys.size() - 1)];
    // A near key shares at least its top 20 bits, so it needs at most 12 new nodes.
    if (src == KEY_NEAR) base ^= $urandom & ((32'd1 << $urandom_range(1, 12)) - 32'd1);
    return base;
  endfunction

  task automatic random_item(int query_pct, int fresh_pct, int near_pct);
    int roll, src;
    logic [btmx_pkg::KEY_BITS-1:0] k;
    roll = $urandom_range(0, 99);
    if (roll < query_pct) begin
      // Lookups close to stored keys make the opposite-bit choice matter deep
      // in the walk; the complement of a stored key finds that key itself.
      case ($urandom_range(0, 3))
        0: k = ~pick_key(KEY_REPEAT);
        1: k = pick_key(KEY_NEAR);
        default: k = $urandom;
      endcase
      offer(btmx_pkg::OP_QUERY, k, btmx_pkg::TAG_BITS'($urandom));
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < fresh_pct) src = KEY_FRESH;
      else if (roll < fresh_pct + near_pct) src = KEY_NEAR;
      else src = KEY_REPEAT;
      offer(btmx_pkg::OP_INSERT, pick_key(src), btmx_pkg::TAG_BITS'($urandom));
    end
  endtask

  initial begin : stimulus
    mirror = new();
    rst       <= 1'b1;
    req_valid <= 1'b0;
    operation <= btmx_pkg::OP_INSERT;
    key       <= '0;
    tag       <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Lookups on an empty trie report not-found.
    offer(btmx_pkg::OP_QUERY, '0, '0);
    offer(btmx_pkg::OP_QUERY, '1, '1);
    offer(btmx_pkg::OP_INSERT, '0, '0);
    offer(btmx_pkg::OP_QUERY, '0, '1);
    offer(btmx_pkg::OP_INSERT, '1, '1);
    offer(btmx_pkg::OP_QUERY, '0, '0);
    offer(btmx_pkg::OP_QUERY, '1, '0);
    // Inserting a stored key again only replaces its tag.
    offer(btmx_pkg::OP_INSERT, '0, 10'h155);
    offer(btmx_pkg::OP_QUERY, '1, '0);
    offer(btmx_pkg::OP_INSERT, 32'h8000_0000, 10'h2aa);
    offer(btmx_pkg::OP_INSERT, 32'h7fff_ffff, 10'h200);
    offer(btmx_pkg::OP_QUERY, 32'h8000_0000, '0);
    offer(btmx_pkg::OP_QUERY, 32'h0000_0001, '0);
    offer(btmx_pkg::OP_INSERT, 32'hffff_fffe, 10'h001);
    offer(btmx_pkg::OP_QUERY, 32'h0000_0001, '0);
    offer(btmx_pkg::OP_QUERY, 32'h5555_5555, '0);
    offer(btmx_pkg::OP_QUERY, 32'haaaa_aaaa, '0);

    wait_drained();

    // Mixed traffic while the response side backs up for a long stretch.
    hold_rsp = 1'b1;
    repeat (60) random_item(45, 50, 30);

    // Mostly fresh keys until the pool is nearly spent.
    while (mirror.nodes_left() >= btmx_pkg::KEY_BITS && items_sent < 1500) begin
      random_item(5, 95, 0);
    end

    // Near a full pool some inserts still fit and others are refused.
    repeat (20) random_item(35, 40, 30);
    quiet = 1'b1;
    repeat (30) random_item(35, 40, 30);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mirror.pending_answers.size() != 0) begin
      $error("%0d results never arrived", mirror.pending_answers.size());
      mirror.mismatches++;
    end
    $display("tb: %0d items sent (%0d inserts, %0d lookups), %0d results compared",
             items_sent, inserts_sent, queries_sent, mirror.answers_seen);
    $display("tb: %0d of %0d pool nodes in use, %0d inserts refused, %0d empty-trie lookups",
             mirror.free_ptr, btmx_pkg::NODE_COUNT, mirror.refusals, mirror.empty_lookups);
    if (mirror.mismatches == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

[sim.f]
design/btmx_pkg.sv
design/btmx_front.sv
design/btmx_back.sv
design/binary_trie_max_xor.sv
tb/tb.sv
